>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ecrf_pkg.sv
`timescale 1ns / 1ps

package ecrf_pkg;

    localparam logic [2:0] FUNC_CHANGE = 3'd0;
    localparam logic [2:0] FUNC_CHECK  = 3'd1;
    localparam logic [2:0] FUNC_SAVE   = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_DONE   = 3'd4;
    localparam logic [2:0] FUNC_READ   = 3'd5;

    localparam logic [2:0] REG_FLUSH_PERIOD = 3'd0;
    localparam logic [2:0] REG_DIRTY_THRESH = 3'd1;
    localparam logic [2:0] REG_BASE_ADDR    = 3'd2;
    localparam logic [2:0] REG_SLOT_STRIDE  = 3'd3;
    localparam logic [2:0] REG_VERSION      = 3'd4;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_COUNT  = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  FILL_BYTE = 8'hFF;

    localparam logic [31:0] PERIOD_RST    = 32'd10000;
    localparam logic [31:0] THRESHOLD_RST = 32'd4;
    localparam logic [15:0] BASE_RST      = 16'h0200;
    localparam logic [10:0] STRIDE_RST    = 11'd64;
    localparam logic [31:0] VERSION_RST   = 32'd1;
    localparam logic [31:0] PENDING_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  relay_index;
        logic        prev_level;
        logic        curr_level;
        logic [31:0] now_ms;
        logic        write_ok;
    } s_payload_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] record_address;
        logic [5:0]  byte_offset;
        logic [7:0]  data_byte;
        logic [63:0] count_value;
        logic        last;
    } m_payload_t;

    typedef struct packed {
        logic inc;
        logic clear;
        logic commit;
    } cnt_ctrl_t;

    typedef struct packed {
        logic start_rec;
        logic reply;
    } ser_cmd_t;

    typedef enum logic {
        SER_IDLE,
        SER_STREAM
    } ser_state_t;

endpackage

>>> sv/ecrf_counters.sv
`timescale 1ns / 1ps

module ecrf_counters import ecrf_pkg::*; #(
    parameter int NUM_RELAYS = 4,
    parameter int NUM_SLOTS  = 2,
    parameter int IDX_W      = 2,
    parameter int SLOT_W     = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cnt_ctrl_t                ctrl,
    input  logic [IDX_W-1:0]         sel,
    input  logic                     sel_valid,
    input  logic [31:0]              now_ms,
    input  logic [31:0]              flush_period_ms,
    input  logic [31:0]              dirty_threshold,
    output logic [NUM_RELAYS*64-1:0] counts,
    output logic [63:0]              rd_count,
    output logic [31:0]              pending,
    output logic [31:0]              seq,
    output logic [SLOT_W-1:0]        slot,
    output logic                     flush_due
);

    localparam logic [SLOT_W-1:0] SLOT_RST  = SLOT_W'(1 % NUM_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    logic [63:0]       cnt_reg [NUM_RELAYS];
    logic [63:0]       cnt_sel;
    logic [63:0]       cnt_inc;
    logic [31:0]       pending_reg, pending_next;
    logic [31:0]       seq_reg, seq_next;
    logic [31:0]       last_time_reg, last_time_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [31:0]       elapsed;

    assign cnt_sel  = sel_valid ? cnt_reg[sel] : 64'd0;
    assign cnt_inc  = cnt_sel + 64'd1;
    assign rd_count = cnt_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_RELAYS; r++) begin
                cnt_reg[r] <= '0;
            end
        end else begin
            for (int r = 0; r < NUM_RELAYS; r++) begin
                if (ctrl.clear) begin
                    cnt_reg[r] <= '0;
                end else if (ctrl.inc && sel_valid && sel == IDX_W'(r)) begin
                    cnt_reg[r] <= cnt_inc;
                end
            end
        end
    end

    always_comb begin
        pending_next   = pending_reg;
        seq_next       = seq_reg;
        last_time_next = last_time_reg;
        slot_next      = slot_reg;
        priority if (ctrl.clear) begin
            pending_next = 32'd1;
        end else if (ctrl.commit) begin
            pending_next   = '0;
            seq_next       = seq_reg + 32'd1;
            last_time_next = now_ms;
            slot_next      = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
        end else if (ctrl.inc && pending_reg != PENDING_MAX) begin
            pending_next = pending_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 32'd1;
            seq_reg       <= '0;
            last_time_reg <= '0;
            slot_reg      <= SLOT_RST;
        end else begin
            pending_reg   <= pending_next;
            seq_reg       <= seq_next;
            last_time_reg <= last_time_next;
            slot_reg      <= slot_next;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_RELAYS; r++) begin
            counts[r*64 +: 64] = cnt_reg[r];
        end
    end

    assign elapsed   = now_ms - last_time_reg;
    assign flush_due = (pending_reg != '0)
                       && (elapsed >= flush_period_ms || pending_reg >= dirty_threshold);
    assign pending   = pending_reg;
    assign seq       = seq_reg;
    assign slot      = slot_reg;

endmodule

>>> sv/ecrf_serializer.sv
`timescale 1ns / 1ps

module ecrf_serializer import ecrf_pkg::*; #(
    parameter int NUM_RELAYS = 4,
    parameter int SLOT_W     = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ser_cmd_t                 cmd,
    input  logic [31:0]              seq_next,
    input  logic [31:0]              version,
    input  logic [NUM_RELAYS*64-1:0] counts,
    input  logic [15:0]              base_address,
    input  logic [10:0]              slot_stride,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [63:0]              reply_value,
    output logic                     idle_ready,
    output logic                     m_valid,
    input  logic                     m_ready,
    output m_payload_t               m_payload
);

    localparam int BODY_BYTES = 8 + 8 * NUM_RELAYS;
    localparam int REC_LEN    = BODY_BYTES + 4;
    localparam int CNT_W      = ($clog2(REC_LEN) > 6) ? $clog2(REC_LEN) : 6;
    localparam int SH_W       = BODY_BYTES * 8;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    ser_state_t        state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    m_payload_t        m_payload_reg, m_payload_next;
    logic [SH_W-1:0]   sh_reg, sh_next;
    logic [15:0]       crc_reg, crc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       addr_reg, addr_next;
    logic              out_free;
    logic              is_last;
    logic [7:0]        cur_byte;
    logic [SLOT_W+10:0] slot_ofs;

    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (cnt_reg == CNT_W'(REC_LEN - 1));
    assign slot_ofs = slot * slot_stride;

    always_comb begin
        priority if (cnt_reg < CNT_W'(BODY_BYTES)) begin
            cur_byte = sh_reg[7:0];
        end else if (cnt_reg == CNT_W'(BODY_BYTES)) begin
            cur_byte = crc_reg[7:0];
        end else if (cnt_reg == CNT_W'(BODY_BYTES + 1)) begin
            cur_byte = crc_reg[15:8];
        end else begin
            cur_byte = FILL_BYTE;
        end
    end

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        sh_next        = sh_reg;
        crc_next       = crc_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        idle_ready     = 1'b0;
        unique case (state_reg)
            SER_IDLE: begin
                idle_ready = out_free;
                if (out_free && cmd.reply) begin
                    m_valid_next               = 1'b1;
                    m_payload_next             = '0;
                    m_payload_next.kind        = KIND_COUNT;
                    m_payload_next.count_value = reply_value;
                    m_payload_next.last        = 1'b1;
                end
                if (out_free && cmd.start_rec) begin
                    sh_next    = {counts, version, seq_next};
                    crc_next   = CRC_INIT;
                    cnt_next   = '0;
                    addr_next  = base_address + 16'(slot_ofs);
                    state_next = SER_STREAM;
                end
            end
            SER_STREAM: begin
                if (out_free) begin
                    m_valid_next                  = 1'b1;
                    m_payload_next.kind           = KIND_RECORD;
                    m_payload_next.record_address = addr_reg;
                    m_payload_next.byte_offset    = cnt_reg[5:0];
                    m_payload_next.data_byte      = cur_byte;
                    m_payload_next.count_value    = '0;
                    m_payload_next.last           = is_last;
                    if (cnt_reg < CNT_W'(BODY_BYTES)) begin
                        sh_next  = sh_reg >> 8;
                        crc_next = crc_byte(crc_reg, sh_reg[7:0]);
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (is_last) begin
                        state_next = SER_IDLE;
                    end
                end
            end
            default: begin
                state_next = SER_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SER_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
        sh_reg        <= sh_next;
        crc_reg       <= crc_next;
        cnt_reg       <= cnt_next;
        addr_reg      <= addr_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

>>> sv/event_counter_record_flusher.sv
`timescale 1ns / 1ps

// channel  ports                                    transfer
// input    s_valid, s_ready, s_payload              s_valid & s_ready
// result   m_valid, m_ready, m_payload              m_valid & m_ready
// config   cfg_we, cfg_index, cfg_wdata             cfg_we
//
// Count read: the reply sits in the output register.
// Record: the shift register is loaded, then 12 + 8*NUM_RELAYS bytes go out,
// one byte per cycle unless m_ready stalls it, through the byte shifter and serial CRC;
// s_ready is low meanwhile. m_ready low stalls the byte stream; reset is synchronous,
// active low, no clearing pass.

module event_counter_record_flusher import ecrf_pkg::*; #(
    parameter int NUM_RELAYS = 4,
    parameter int NUM_SLOTS  = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  s_payload_t s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output m_payload_t m_payload,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_wdata
);

    `include "assert_macros.svh"

    localparam int IDX_W   = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int REC_LEN = 12 + 8 * NUM_RELAYS;

    logic [31:0] period_reg;
    logic [31:0] threshold_reg;
    logic [15:0] base_reg;
    logic [10:0] stride_reg;
    logic [31:0] version_reg;

    logic                     accept;
    logic                     sel_valid;
    cnt_ctrl_t                ctrl;
    ser_cmd_t                 cmd;
    logic [NUM_RELAYS*64-1:0] counts;
    logic [NUM_RELAYS*64-1:0] rec_counts;
    logic [63:0]              rd_count;
    logic [31:0]              pending;
    logic [31:0]              seq;
    logic [SLOT_W-1:0]        slot;
    logic                     flush_due;

    logic                     rec_end_out;
    logic                     rec_end_ok;
    logic                     reply_out;
    logic                     reply_ok;
    logic                     save_in;
    logic                     commit_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= PERIOD_RST;
            threshold_reg <= THRESHOLD_RST;
            base_reg      <= BASE_RST;
            stride_reg    <= STRIDE_RST;
            version_reg   <= VERSION_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FLUSH_PERIOD: period_reg    <= cfg_wdata;
                REG_DIRTY_THRESH: threshold_reg <= cfg_wdata;
                REG_BASE_ADDR:    base_reg      <= cfg_wdata[15:0];
                REG_SLOT_STRIDE:  stride_reg    <= cfg_wdata[10:0];
                REG_VERSION:      version_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign accept    = s_valid && s_ready;
    assign sel_valid = (s_payload.relay_index < 8'(NUM_RELAYS));

    always_comb begin
        ctrl = '0;
        cmd  = '0;
        if (accept) begin
            unique case (s_payload.func)
                FUNC_CHANGE: ctrl.inc = sel_valid
                                        && (s_payload.prev_level != s_payload.curr_level);
                FUNC_CHECK:  cmd.start_rec = flush_due;
                FUNC_SAVE:   cmd.start_rec = 1'b1;
                FUNC_CLEAR: begin
                    ctrl.clear    = 1'b1;
                    cmd.start_rec = 1'b1;
                end
                FUNC_DONE:   ctrl.commit = s_payload.write_ok;
                FUNC_READ:   cmd.reply = 1'b1;
                default: ;
            endcase
        end
    end

    assign rec_counts = ctrl.clear ? '0 : counts;

    ecrf_counters #(
        .NUM_RELAYS (NUM_RELAYS),
        .NUM_SLOTS  (NUM_SLOTS),
        .IDX_W      (IDX_W),
        .SLOT_W     (SLOT_W)
    ) u_counters (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .sel             (s_payload.relay_index[IDX_W-1:0]),
        .sel_valid       (sel_valid),
        .now_ms          (s_payload.now_ms),
        .flush_period_ms (period_reg),
        .dirty_threshold (threshold_reg),
        .counts          (counts),
        .rd_count        (rd_count),
        .pending         (pending),
        .seq             (seq),
        .slot            (slot),
        .flush_due       (flush_due)
    );

    ecrf_serializer #(
        .NUM_RELAYS (NUM_RELAYS),
        .SLOT_W     (SLOT_W)
    ) u_serializer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .seq_next     (seq + 32'd1),
        .version      (version_reg),
        .counts       (rec_counts),
        .base_address (base_reg),
        .slot_stride  (stride_reg),
        .slot         (slot),
        .reply_value  (rd_count),
        .idle_ready   (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload)
    );

    assign rec_end_out = m_valid && m_payload.kind == KIND_RECORD && m_payload.last;
    assign rec_end_ok  = m_payload.byte_offset == 6'(REC_LEN - 1);
    assign reply_out   = m_valid && m_payload.kind == KIND_COUNT;
    assign reply_ok    = m_payload.last && m_payload.data_byte == 8'd0
                         && m_payload.record_address == 16'd0;
    assign save_in     = accept && s_payload.func == FUNC_SAVE;
    assign commit_in   = accept && s_payload.func == FUNC_DONE && s_payload.write_ok;

    `ASSERT_IMPLIES(a_record_end, aclk, aresetn, rec_end_out, rec_end_ok, "record end offset")

    `ASSERT_IMPLIES(a_reply_shape, aclk, aresetn, reply_out, reply_ok, "count reply malformed")

    `ASSERT_NEXT(a_save_blocks, aclk, aresetn, save_in, !s_ready, "input open during record")

    `ASSERT_NEXT(a_commit_clears, aclk, aresetn, commit_in, pending == 32'd0, "pending not cleared")

endmodule

>>> verif/event_counter_record_flusher_test.sv
`timescale 1ns / 1ps

module event_counter_record_flusher_test;
    import ecrf_pkg::*;

    localparam int RELAYS = 4;
    localparam int SLOTS = 2;
    localparam int REC_BODY = 8 + 8 * RELAYS;
    localparam int REC_LEN = REC_BODY + 4;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    s_payload_t  s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    m_payload_t  m_payload;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // predictor state and shadow configuration
    logic [63:0] toggles [RELAYS];
    logic [31:0] dirty_count;
    logic [31:0] seq_committed;
    logic [31:0] flushed_at;
    logic [31:0] period_ms;
    logic [31:0] dirty_limit;
    logic [15:0] slot0_addr;
    logic [10:0] stride;
    logic [31:0] rec_version;

    m_payload_t  expected_out [$];
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b0;
    int          ready_hold = 0;
    logic [31:0] tick_ms = '0;

    event_counter_record_flusher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver stall pattern: long ready runs, short and long stalls
    always @(negedge aclk) begin
        int pick;
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                m_ready = 1'b1;
                ready_hold = $urandom_range(0, 30);
            end else if (pick < 8) begin
                m_ready = 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else begin
                m_ready = 1'b0;
                ready_hold = $urandom_range(3, 12);
            end
        end
    end

    function automatic void reset_shadow();
        for (int i = 0; i < RELAYS; i++) toggles[i] = '0;
        dirty_count = 32'd1;
        seq_committed = '0;
        flushed_at = '0;
        period_ms = PERIOD_RST;
        dirty_limit = THRESHOLD_RST;
        slot0_addr = BASE_RST;
        stride = STRIDE_RST;
        rec_version = VERSION_RST;
    endfunction

    // builds the 44-byte record and queues one byte transfer per position
    function automatic void stream_record();
        logic [7:0]  rec [REC_LEN];
        logic [31:0] seq;
        logic [31:0] addr_wide;
        logic [15:0] crc;
        m_payload_t  r;
        seq = seq_committed + 32'd1;
        for (int i = 0; i < REC_LEN; i++) rec[i] = FILL_BYTE;
        for (int i = 0; i < 4; i++) begin
            rec[i] = seq[8*i +: 8];
            rec[4 + i] = rec_version[8*i +: 8];
        end
        for (int n = 0; n < RELAYS; n++)
            for (int b = 0; b < 8; b++) rec[8 + 8*n + b] = toggles[n][8*b +: 8];
        crc = CRC_INIT;
        for (int i = 0; i < REC_BODY; i++) begin
            crc = crc ^ {rec[i], 8'h00};
            for (int b = 0; b < 8; b++)
                crc = crc[15] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
        rec[REC_BODY] = crc[7:0];
        rec[REC_BODY + 1] = crc[15:8];
        addr_wide = {16'h0, slot0_addr} + (seq % SLOTS) * {21'h0, stride};
        for (int i = 0; i < REC_LEN; i++) begin
            r.kind = KIND_RECORD;
            r.record_address = addr_wide[15:0];
            r.byte_offset = 6'(i);
            r.data_byte = rec[i];
            r.count_value = '0;
            r.last = (i == REC_LEN - 1);
            expected_out.push_back(r);
        end
    endfunction

    function automatic void advance_counters(input s_payload_t p);
        logic [31:0] elapsed;
        m_payload_t  r;
        case (p.func)
            FUNC_CHANGE: begin
                if (p.relay_index < RELAYS && p.prev_level != p.curr_level) begin
                    toggles[p.relay_index] = toggles[p.relay_index] + 64'd1;
                    if (dirty_count != PENDING_MAX) dirty_count = dirty_count + 32'd1;
                end
            end
            FUNC_CHECK: begin
                elapsed = p.now_ms - flushed_at;
                if (dirty_count != 0 && (elapsed >= period_ms || dirty_count >= dirty_limit))
                    stream_record();
            end
            FUNC_SAVE: begin
                stream_record();
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < RELAYS; i++) toggles[i] = '0;
                dirty_count = 32'd1;
                stream_record();
            end
            FUNC_DONE: begin
                if (p.write_ok) begin
                    seq_committed = seq_committed + 32'd1;
                    dirty_count = '0;
                    flushed_at = p.now_ms;
                end
            end
            FUNC_READ: begin
                r.kind = KIND_COUNT;
                r.record_address = '0;
                r.byte_offset = '0;
                r.data_byte = '0;
                r.count_value = (p.relay_index < RELAYS) ? toggles[p.relay_index] : 64'd0;
                r.last = 1'b1;
                expected_out.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        m_payload_t e;
        string bad;
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("extra %0t: kind=%0d addr=%h off=%0d byte=%h cnt=%h last=%0d",
                             $realtime, m_payload.kind, m_payload.record_address,
                             m_payload.byte_offset, m_payload.data_byte,
                             m_payload.count_value, m_payload.last);
            end else begin
                e = expected_out.pop_front();
                bad = "";
                if (m_payload.kind !== e.kind) bad = {bad, " kind"};
                if (m_payload.record_address !== e.record_address) bad = {bad, " record_address"};
                if (m_payload.byte_offset !== e.byte_offset) bad = {bad, " byte_offset"};
                if (m_payload.data_byte !== e.data_byte) bad = {bad, " data_byte"};
                if (m_payload.count_value !== e.count_value) bad = {bad, " count_value"};
                if (m_payload.last !== e.last) bad = {bad, " last"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t in%s", $realtime, bad);
                        $display("  exp kind=%0d addr=%h off=%0d byte=%h cnt=%h last=%0d",
                                 e.kind, e.record_address, e.byte_offset, e.data_byte,
                                 e.count_value, e.last);
                        $display("  got kind=%0d addr=%h off=%0d byte=%h cnt=%h last=%0d",
                                 m_payload.kind, m_payload.record_address,
                                 m_payload.byte_offset, m_payload.data_byte,
                                 m_payload.count_value, m_payload.last);
                    end
                end
            end
        end
    end

    task automatic send_item(input s_payload_t p);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_payload = p;
        do @(posedge aclk); while (!s_ready);
        advance_counters(p);
        if (burst_left > 0) burst_left--;
    endtask

    // sender holds off until every queued transfer has arrived
    task automatic wait_for_quiet();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (expected_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_FLUSH_PERIOD: period_ms = val;
            REG_DIRTY_THRESH: dirty_limit = val;
            REG_BASE_ADDR:    slot0_addr = val[15:0];
            REG_SLOT_STRIDE:  stride = val[10:0];
            REG_VERSION:      rec_version = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic [31:0] period, input logic [31:0] thresh,
                              input logic [15:0] base, input logic [10:0] step,
                              input logic [31:0] version);
        wait_for_quiet();
        write_reg(REG_FLUSH_PERIOD, period);
        write_reg(REG_DIRTY_THRESH, thresh);
        write_reg(REG_BASE_ADDR, {16'h0, base});
        write_reg(REG_SLOT_STRIDE, {21'h0, step});
        write_reg(REG_VERSION, version);
    endtask

    function automatic s_payload_t mk_item(input logic [2:0] f, input logic [7:0] idx,
                                           input logic o, input logic n,
                                           input logic [31:0] t, input logic ok);
        s_payload_t p;
        p.func = f;
        p.relay_index = idx;
        p.prev_level = o;
        p.curr_level = n;
        p.now_ms = t;
        p.write_ok = ok;
        return p;
    endfunction

    function automatic s_payload_t rand_item();
        s_payload_t p;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)      p.func = FUNC_CHANGE;
        else if (pick < 54) p.func = FUNC_CHECK;
        else if (pick < 60) p.func = FUNC_SAVE;
        else if (pick < 64) p.func = FUNC_CLEAR;
        else if (pick < 78) p.func = FUNC_DONE;
        else if (pick < 95) p.func = FUNC_READ;
        else                p.func = $urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7;
        p.relay_index = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, RELAYS - 1))
                                                     : 8'($urandom_range(0, 255));
        p.prev_level = 1'($urandom_range(0, 1));
        p.curr_level = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 19) == 0) tick_ms = $urandom();
        else tick_ms = tick_ms + $urandom_range(0, 4000);
        p.now_ms = tick_ms;
        p.write_ok = ($urandom_range(0, 9) < 8);
        return p;
    endfunction

    // flush requests are mostly followed by a successful write acknowledge
    task automatic run_traffic(input int n_items);
        s_payload_t p;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            p = rand_item();
            send_item(p);
            sent++;
            if ((p.func == FUNC_CHECK || p.func == FUNC_SAVE || p.func == FUNC_CLEAR) &&
                sent < n_items && $urandom_range(0, 9) < 7) begin
                tick_ms = tick_ms + $urandom_range(1, 500);
                send_item(mk_item(FUNC_DONE, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  tick_ms, 1'b1));
                sent++;
            end
        end
    endtask

    task automatic test_after_reset();
        gaps_on = 1'b0;
        send_item(mk_item(FUNC_READ, 8'd0, 1'b0, 1'b0, 32'd0, 1'b0));
        send_item(mk_item(FUNC_READ, 8'd255, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_item(mk_item(FUNC_CHECK, 8'd0, 1'b0, 1'b0, 32'd0, 1'b0));
        send_item(mk_item(FUNC_CHECK, 8'd0, 1'b0, 1'b0, 32'd10000, 1'b0));
        send_item(mk_item(FUNC_SAVE, 8'd0, 1'b0, 1'b0, 32'd10001, 1'b0));
        send_item(mk_item(FUNC_DONE, 8'd0, 1'b0, 1'b0, 32'd7, 1'b0));
        send_item(mk_item(FUNC_DONE, 8'd0, 1'b0, 1'b0, 32'd20, 1'b1));
        send_item(mk_item(FUNC_CHECK, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0));
        send_item(mk_item(FUNC_SPARE6, 8'd0, 1'b0, 1'b1, 32'd30, 1'b1));
        send_item(mk_item(FUNC_SPARE7, 8'd1, 1'b1, 1'b0, 32'd31, 1'b1));
    endtask

    task automatic test_relay_events();
        gaps_on = 1'b1;
        send_item(mk_item(FUNC_CHANGE, 8'd0, 1'b0, 1'b1, 32'd21, 1'b0));
        send_item(mk_item(FUNC_CHANGE, 8'd1, 1'b1, 1'b0, 32'd21, 1'b0));
        send_item(mk_item(FUNC_CHANGE, 8'd2, 1'b1, 1'b1, 32'd21, 1'b0));
        send_item(mk_item(FUNC_CHANGE, 8'd4, 1'b0, 1'b1, 32'd21, 1'b0));
        send_item(mk_item(FUNC_CHANGE, 8'd255, 1'b1, 1'b0, 32'd21, 1'b0));
        send_item(mk_item(FUNC_CHANGE, 8'd3, 1'b0, 1'b1, 32'd21, 1'b0));
        send_item(mk_item(FUNC_CHECK, 8'd0, 1'b0, 1'b0, 32'd21, 1'b0));
        send_item(mk_item(FUNC_CHANGE, 8'd3, 1'b1, 1'b0, 32'd22, 1'b0));
        send_item(mk_item(FUNC_CHECK, 8'd0, 1'b0, 1'b0, 32'd22, 1'b0));
        send_item(mk_item(FUNC_READ, 8'd3, 1'b0, 1'b0, 32'd22, 1'b0));
        send_item(mk_item(FUNC_CLEAR, 8'd0, 1'b0, 1'b0, 32'd23, 1'b0));
        send_item(mk_item(FUNC_READ, 8'd0, 1'b0, 1'b0, 32'd23, 1'b0));
    endtask

    // elapsed time is taken modulo 2^32 across the tick wrap
    task automatic test_tick_wrap();
        send_item(mk_item(FUNC_DONE, 8'd0, 1'b0, 1'b0, 32'hFFFF_FF00, 1'b1));
        send_item(mk_item(FUNC_CHANGE, 8'd0, 1'b1, 1'b0, 32'hFFFF_FF10, 1'b0));
        send_item(mk_item(FUNC_CHECK, 8'd0, 1'b0, 1'b0, 32'h0000_2000, 1'b0));
        send_item(mk_item(FUNC_CHECK, 8'd0, 1'b0, 1'b0, 32'h0000_2610, 1'b0));
        wait_for_quiet();
    endtask

    task automatic test_config_sweep();
        gaps_on = 1'b1;
        set_config(32'd0, 32'd1, 16'hFFFF, 11'd1024, 32'hFFFF_FFFF);
        run_traffic(30);
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 11'd44, 32'h0000_0000);
        run_traffic(30);
        repeat (2) begin
            set_config($urandom_range(0, 20000), $urandom_range(1, 8), 16'($urandom()),
                       11'($urandom_range(44, 1024)), $urandom());
            run_traffic(30);
        end
    endtask

    task automatic test_random_traffic();
        set_config(PERIOD_RST, THRESHOLD_RST, BASE_RST, STRIDE_RST, VERSION_RST);
        gaps_on = 1'b0;
        run_traffic(40);
        gaps_on = 1'b1;
        run_traffic(45);
        wait_for_quiet();
        run_traffic(45);
    endtask

    initial begin
        reset_shadow();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_after_reset();
        test_relay_events();
        test_tick_wrap();
        test_config_sweep();
        test_random_traffic();
        wait_for_quiet();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> event_counter_record_flusher.f
+incdir+sv
sv/ecrf_pkg.sv
sv/ecrf_counters.sv
sv/ecrf_serializer.sv
sv/event_counter_record_flusher.sv
verif/event_counter_record_flusher_test.sv
